[rtl/bm25tw_pkg.sv]
package bm25tw_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StDfHigh  = 2'd1,
    StZeroDen = 2'd2,
    StSat     = 2'd3
  } status_e;

  // Configuration register indexes.
  localparam logic [1:0] CfgAvgLen  = 2'd0;
  localparam logic [1:0] CfgCollSz  = 2'd1;
  localparam logic [1:0] CfgSatK    = 2'd2;
  localparam logic [1:0] CfgLenNrmB = 2'd3;

  localparam logic [23:0] AvgLenRst  = 24'd25600;
  localparam logic [23:0] CollSzRst  = 24'd1;
  localparam logic [15:0] SatKRst    = 16'd4915;
  localparam logic [12:0] LenNrmBRst = 13'd3072;

  localparam logic [12:0] BOne   = 13'd4096;
  localparam logic [31:0] Ln2Q32 = 32'd2977044472;

  // Back pipeline schedule.
  localparam int RatioSteps = 36;
  localparam int LogSteps   = 24;
  localparam int SNorm      = 36;
  localparam int SDen       = 37;
  localparam int FSteps     = 21;
  localparam int SF0        = 38;
  localparam int SIdf       = SF0 + FSteps;
  localparam int SWt        = SIdf + 1;
  localparam int SOut       = SWt + 1;
  localparam int NumStages  = SOut + 1;

  localparam int MidDepthDef = 2;
  localparam int OutDepthDef = 2;

  typedef struct packed {
    logic [23:0] avg;
    logic [23:0] n;
    logic [15:0] k;
    logic [12:0] b;
  } cfg_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    status_e     status;
    logic [15:0] tf;
    logic [15:0] len;
    logic [4:0]  ae;
    logic [31:0] am;
    logic [4:0]  ce;
    logic [31:0] cm;
  } entry_t;

  typedef struct packed {
    logic [31:0] weight;
    status_e     status;
  } res_t;

endpackage

[rtl/bm25tw_fifo.sv]
module bm25tw_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/bm25tw_front.sv]
module bm25tw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bm25tw_pkg::cfg_t  cfg_i,
  input  logic              push_i,
  output logic              full_o,
  input  logic [15:0]       term_count_i,
  input  logic [23:0]       doc_freq_i,
  input  logic [15:0]       doc_length_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output bm25tw_pkg::entry_t q_data_o
);
  import bm25tw_pkg::*;

  // Position of the leading one; the argument is never zero here.
  function automatic logic [4:0] msb_idx(logic [24:0] x);
    logic [4:0] e;
    e = '0;
    for (int i = 0; i < 25; i++) begin
      if (x[i]) e = 5'(i);
    end
    return e;
  endfunction

  logic        fr_valid_q, fr_valid_d;
  entry_t      fr_q, fr_d;
  logic        load;
  logic [24:0] xa, xc;

  assign full_o    = fr_valid_q && !q_ready_i;
  assign load      = push_i && !full_o;
  assign q_valid_o = fr_valid_q;
  assign q_data_o  = fr_q;

  always_comb begin
    xa = {cfg_i.n - doc_freq_i, 1'b1};
    xc = {doc_freq_i, 1'b1};
    fr_d.tf  = term_count_i;
    fr_d.len = doc_length_i;
    fr_d.ae  = msb_idx(xa);
    fr_d.ce  = msb_idx(xc);
    fr_d.am  = 32'(xa) << (5'd30 - fr_d.ae);
    fr_d.cm  = 32'(xc) << (5'd30 - fr_d.ce);
    if (doc_freq_i > cfg_i.n) begin
      fr_d.status = StDfHigh;
    end else if (cfg_i.avg == '0) begin
      fr_d.status = StZeroDen;
    end else begin
      fr_d.status = StOk;
    end
    fr_valid_d = load ? 1'b1 : (fr_valid_q && !q_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      fr_q <= fr_d;
    end
  end

endmodule

[rtl/bm25tw_back.sv]
module bm25tw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bm25tw_pkg::cfg_t   cfg_i,
  input  logic               in_valid_i,
  input  bm25tw_pkg::entry_t in_data_i,
  output logic               in_pop_o,
  input  logic               out_full_i,
  output logic               out_push_o,
  output bm25tw_pkg::res_t   out_data_o
);
  import bm25tw_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [15:0] tf;
    logic [15:0] len;
    logic [23:0] rrem;
    logic [35:0] ratio;
    logic [31:0] am;
    logic [31:0] cm;
    logic [28:0] al;
    logic [28:0] cl;
    logic [37:0] norm;
    logic [55:0] den;
    logic [56:0] frem;
    logic [20:0] f;
    logic        neg;
    logic [28:0] idf;
    logic [31:0] weight;
  } work_t;

  // One squaring step of the mantissa: {fraction bit, new mantissa}.
  function automatic logic [32:0] sq_step(logic [31:0] m);
    logic [63:0] sq;
    logic [31:0] m2;
    sq = 64'(m) * 64'(m);
    m2 = sq[61:30];
    return m2[31] ? {1'b1, 1'b0, m2[31:1]} : {1'b0, m2};
  endfunction

  logic                 adv;
  logic [12:0]          b_eff;
  work_t                cur [NumStages];
  work_t                nxt [NumStages];
  work_t                pipe_q [NumStages];
  logic [NumStages-1:0] vld_q;

  assign adv        = !out_full_i;
  assign in_pop_o   = adv && in_valid_i;
  assign out_push_o = adv && vld_q[NumStages-1];
  assign b_eff      = (cfg_i.b > BOne) ? BOne : cfg_i.b;

  always_comb begin
    out_data_o.weight = pipe_q[NumStages-1].weight;
    out_data_o.status = pipe_q[NumStages-1].status;
  end

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    if (s == 0) begin : g_head
      always_comb begin
        cur[0]        = '0;
        cur[0].status = in_data_i.status;
        cur[0].tf     = in_data_i.tf;
        cur[0].len    = in_data_i.len;
        cur[0].am     = in_data_i.am;
        cur[0].cm     = in_data_i.cm;
        cur[0].al     = {in_data_i.ae, 24'b0};
        cur[0].cl     = {in_data_i.ce, 24'b0};
      end
    end else begin : g_link
      assign cur[s] = pipe_q[s-1];
    end

    always_comb begin : stage_c
      work_t       w;
      logic [24:0] t25;
      logic [32:0] sa, sc;
      logic [48:0] bprod;
      logic [49:0] nsum;
      logic [55:0] dsum;
      logic [32:0] x;
      logic [56:0] t57;
      logic [28:0] dmag;
      logic [61:0] lsum;
      logic [50:0] wsum;
      logic [32:0] lim;
      w     = cur[s];
      t25   = '0;
      sa    = '0;
      sc    = '0;
      bprod = '0;
      nsum  = '0;
      dsum  = '0;
      x     = '0;
      t57   = '0;
      dmag  = '0;
      lsum  = '0;
      wsum  = '0;
      lim   = '0;
      if (s < RatioSteps) begin
        // Restoring division of len << 20 by the average length.
        t25   = {w.rrem, w.len[15]};
        w.len = {w.len[14:0], 1'b0};
        if (t25 >= {1'b0, cfg_i.avg}) begin
          w.rrem  = 24'(t25 - {1'b0, cfg_i.avg});
          w.ratio = {w.ratio[34:0], 1'b1};
        end else begin
          w.rrem  = t25[23:0];
          w.ratio = {w.ratio[34:0], 1'b0};
        end
      end
      if (s < LogSteps) begin
        sa   = sq_step(w.am);
        sc   = sq_step(w.cm);
        w.am = sa[31:0];
        w.cm = sc[31:0];
        w.al = {w.al[28:24], w.al[22:0], sa[32]};
        w.cl = {w.cl[28:24], w.cl[22:0], sc[32]};
      end
      if (s == SNorm) begin
        bprod  = 49'(b_eff) * 49'(w.ratio);
        nsum   = 50'({BOne - b_eff, 12'b0}) + 50'(bprod);
        w.norm = nsum[49:12];
      end
      if (s == SDen) begin
        dsum   = {16'b0, w.tf, 24'b0} + (56'(cfg_i.k) * 56'(w.norm));
        w.den  = dsum;
        if (dsum == '0 && w.status == StOk) begin
          w.status = StZeroDen;
        end
        x      = 33'(w.tf) * 33'({1'b0, cfg_i.k} + 17'd4096);
        w.frem = 57'(x) << 7;
      end
      if (s >= SF0 && s < SF0 + FSteps) begin
        // The low dividend bits are all zero, so only zeros shift in.
        t57 = {w.frem[55:0], 1'b0};
        if (t57 >= {1'b0, w.den}) begin
          w.frem = t57 - {1'b0, w.den};
          w.f    = {w.f[19:0], 1'b1};
        end else begin
          w.frem = t57;
          w.f    = {w.f[19:0], 1'b0};
        end
      end
      if (s == SIdf) begin
        w.neg = (w.al < w.cl);
        dmag  = w.neg ? (w.cl - w.al) : (w.al - w.cl);
        lsum  = 62'(dmag) * 62'(Ln2Q32) + 62'(64'h8000_0000);
        w.idf = lsum[60:32];
      end
      if (s == SWt) begin
        wsum     = 51'(w.idf) * 51'(w.f) + 51'(32'h0080_0000);
        w.weight = 32'(wsum[50:24]);
      end
      if (s == SOut) begin
        lim = w.neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
        if (w.status != StOk) begin
          w.weight = '0;
        end else begin
          if ({1'b0, w.weight} > lim) begin
            w.weight = lim[31:0];
            w.status = StSat;
          end
          if (w.neg) begin
            w.weight = 32'(0) - w.weight;
          end
        end
      end
      nxt[s] = w;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        pipe_q[s] <= nxt[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], in_pop_o};
    end
  end

endmodule

[rtl/bm25_term_weight_unit.sv]
// Okapi BM25 term weight unit.
// Items enter through a queue-style port: an item (term count, document
// frequency, document length) is taken at a clock edge where push is high and
// full is low. Results leave the same way: while empty is low the oldest
// result (signed Q15.16 weight and a two-bit status) is on the result ports,
// and it is taken at an edge where pop is high.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i) and
// must only be written while no item is in flight.
// A front stage checks the document frequency against the collection size and
// the average length for zero, forms the two log arguments and normalizes their
// mantissas. A short queue then feeds a fully pipelined back end of 62 stages:
// a 36-step divider for the length ratio, 24 squaring steps for each log2 (run
// alongside the divider), the normalization multiply, a 21-step divider for the
// saturated term frequency, and the final multiplies, rounding and saturation.
// One item is accepted every cycle when the result side is not stalled.
// When pop stays low, the output queue fills, the whole back pipeline holds,
// and the middle queue and front stage then fill before full rises.
// Reset empties all queues and pipeline stages and loads the default registers.
module bm25_term_weight_unit #(
  parameter int MidDepth = bm25tw_pkg::MidDepthDef,
  parameter int OutDepth = bm25tw_pkg::OutDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] term_count_i,
  input  logic [23:0] doc_freq_i,
  input  logic [15:0] doc_length_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] weight_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i
);
  import bm25tw_pkg::*;

  cfg_t   cfg_q;
  entry_t fr_data, mid_data;
  res_t   bk_data, out_data;
  logic   fr_valid, mid_full, mid_empty, mid_pop;
  logic   out_full, out_push;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.avg <= AvgLenRst;
      cfg_q.n   <= CollSzRst;
      cfg_q.k   <= SatKRst;
      cfg_q.b   <= LenNrmBRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAvgLen:  cfg_q.avg <= cfg_wdata_i;
        CfgCollSz:  cfg_q.n   <= cfg_wdata_i;
        CfgSatK:    cfg_q.k   <= cfg_wdata_i[15:0];
        CfgLenNrmB: cfg_q.b   <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  bm25tw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push_i       (push),
    .full_o       (full),
    .term_count_i (term_count_i),
    .doc_freq_i   (doc_freq_i),
    .doc_length_i (doc_length_i),
    .q_valid_o    (fr_valid),
    .q_ready_i    (!mid_full),
    .q_data_o     (fr_data)
  );

  bm25tw_fifo #(
    .Width ($bits(entry_t)),
    .Depth (MidDepth)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .wdata_i (fr_data),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_data),
    .empty_o (mid_empty)
  );

  bm25tw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (!mid_empty),
    .in_data_i  (mid_data),
    .in_pop_o   (mid_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_data_o (bk_data)
  );

  bm25tw_fifo #(
    .Width ($bits(res_t)),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (bk_data),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_data),
    .empty_o (empty)
  );

  assign weight_o = out_data.weight;
  assign status_o = out_data.status;

`ifndef SYNTHESIS
  // Rejected items must come out with a zero weight.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o == StDfHigh || status_o == StZeroDen)) |-> (weight_o == '0))
    else $error("rejected item has a nonzero weight");

  // The back end only writes a result when the output queue has room.
  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full)
    else $error("result written into a full output queue");

  // The back end only takes an item that is waiting in the middle queue.
  a_mid_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> !mid_empty)
    else $error("back end popped an empty middle queue");
`endif

endmodule

[tb/bm25_term_weight_unit_tb.sv]
`timescale 1ns / 100ps

module bm25_term_weight_unit_tb;
  import bm25tw_pkg::*;

  // Generous bound on the whole run, in clock cycles.
  localparam int CycleLimit = 400000;
  // Pipeline latency from acceptance to result, plus some slack.
  localparam int DrainCycles = 120;

  typedef struct packed {
    logic [15:0] tf;
    logic [23:0] df;
    logic [15:0] len;
  } term_item_t;

  typedef struct packed {
    logic [31:0] weight;
    status_e     status;
  } weight_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] term_count_i = '0;
  logic [23:0] doc_freq_i = '0;
  logic [15:0] doc_length_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] weight_o;
  logic [1:0]  status_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CfgAvgLen;
  logic [23:0] cfg_wdata_i = '0;

  bm25_term_weight_unit dut (
    .clk_i, .rst_ni, .push, .full, .term_count_i, .doc_freq_i, .doc_length_i,
    .empty, .pop, .weight_o, .status_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  // Testbench copy of the configuration registers.
  logic [23:0] avg_len_q = AvgLenRst;
  logic [23:0] coll_size_q = CollSzRst;
  logic [15:0] sat_k_q = SatKRst;
  logic [12:0] norm_b_q = LenNrmBRst;

  term_item_t  pending_terms[$];
  weight_res_t expected_weights[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          stall_results = 1'b0;

  // log2 of x as unsigned Q.24, by repeated squaring of a Q1.30 mantissa.
  function automatic logic [63:0] log2_fixed(input logic [31:0] x);
    int unsigned e;
    logic [63:0] m;
    logic [63:0] frac;
    e = 0;
    frac = '0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    m = 64'(x) << (30 - e);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(e) << 24) | frac;
  endfunction

  function automatic weight_res_t bm25_weight(input term_item_t it);
    weight_res_t r;
    logic [63:0] b, ratio, norm, den, num, f, la, lc, dmag, idf, wmag, lim;
    logic [127:0] prod;
    bit neg;
    r.weight = '0;
    r.status = StOk;
    b = (norm_b_q > BOne) ? 64'(BOne) : 64'(norm_b_q);
    if (it.df > coll_size_q) begin
      r.status = StDfHigh;
    end else if (avg_len_q == 0) begin
      r.status = StZeroDen;
    end else begin
      ratio = (64'(it.len) << 20) / 64'(avg_len_q);
      norm = ((4096 - b) * 4096 + b * ratio) >> 12;
      den = (64'(it.tf) << 24) + 64'(sat_k_q) * norm;
      if (den == 0) begin
        r.status = StZeroDen;
      end else begin
        num = (64'(it.tf) * (64'(sat_k_q) + 4096)) << 12;
        f = (num << 16) / den;
        la = log2_fixed(32'(2 * (64'(coll_size_q) - 64'(it.df)) + 1));
        lc = log2_fixed(32'(2 * 64'(it.df) + 1));
        neg = la < lc;
        dmag = neg ? lc - la : la - lc;
        prod = 128'(dmag) * 128'(Ln2Q32) + (128'(1) << 31);
        idf = 64'(prod >> 32);
        prod = 128'(idf) * 128'(f) + (128'(1) << 23);
        wmag = 64'(prod >> 24);
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (wmag > lim) begin
          wmag = lim;
          r.status = StSat;
        end
        r.weight = neg ? 32'(0 - wmag) : 32'(wmag);
      end
    end
    return r;
  endfunction

  // Random gap: mostly zero or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: offers pending items, with random gaps outside burst mode, and
  // predicts each one as it is accepted.
  int unsigned push_gap = 0;
  bit burst_mode = 1'b0;
  always @(posedge clk_i) begin
    term_item_t sent_term;
    if (rst_ni) begin
      if (push && !full) begin
        sent_term = pending_terms.pop_front();
        expected_weights = {expected_weights, bm25_weight(sent_term)};
        push_gap = burst_mode ? 0 : pick_gap();
      end
      if (!(push && full)) begin
        if (push_gap > 0) begin
          push_gap--;
          push <= 1'b0;
        end else if (pending_terms.size() > 0) begin
          push <= 1'b1;
          term_count_i <= pending_terms[0].tf;
          doc_freq_i <= pending_terms[0].df;
          doc_length_i <= pending_terms[0].len;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  int unsigned pop_gap = 0;
  always @(posedge clk_i) begin
    weight_res_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_weights.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected result: weight %h status %0d", weight_o, status_o);
        end else begin
          want = expected_weights.pop_front();
          if (weight_o !== want.weight || status_o !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch: expected weight %h status %0d, got weight %h status %0d",
                       want.weight, want.status, weight_o, status_o);
          end
        end
        pop_gap = pick_gap();
      end
      if (stall_results) begin
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_terms.size() > 0 || push || expected_weights.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgAvgLen: avg_len_q = val;
      CfgCollSz: coll_size_q = val;
      CfgSatK: sat_k_q = val[15:0];
      default: norm_b_q = val[12:0];
    endcase
  endtask

  task automatic add_term(input logic [15:0] tf, input logic [23:0] df,
                          input logic [15:0] len);
    term_item_t it;
    it.tf = tf;
    it.df = df;
    it.len = len;
    pending_terms = {pending_terms, it};
  endtask

  // Random item; most document frequencies stay within N.
  task automatic add_random_term();
    logic [23:0] df;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) df = 24'($urandom());
    else if (sel == 1) df = coll_size_q;
    else if (sel == 2) df = '0;
    else df = 24'($urandom_range(0, coll_size_q));
    add_term(($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 20)),
             df,
             ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 400)));
  endtask

  typedef struct {
    logic [23:0] avg;
    logic [23:0] n;
    logic [15:0] k;
    logic [12:0] b;
  } setting_t;

  initial begin
    setting_t settings[6];
    settings[0] = '{24'd25600, 24'd1000000, 16'd4915, 13'd3072};
    settings[1] = '{24'd1, 24'hFFFFFF, 16'hFFFF, 13'd4096};
    settings[2] = '{24'hFFFFFF, 24'd1, 16'd0, 13'd0};
    settings[3] = '{24'd0, 24'd50, 16'd4915, 13'd3072};
    settings[4] = '{24'd3000, 24'd5000, 16'd8192, 13'h1FFF};
    settings[5] = '{24'd12345, 24'd200, 16'd100, 13'd2048};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Defaults after reset: N is one.
    add_term(16'd3, 24'd0, 16'd100);
    add_term(16'd3, 24'd1, 16'd100);
    add_term(16'd3, 24'd2, 16'd100);
    add_term(16'd0, 24'd0, 16'd0);
    wait_drained();

    write_reg(CfgCollSz, 24'd1000000);
    add_term(16'hFFFF, 24'd0, 16'hFFFF);
    add_term(16'hFFFF, 24'd1000000, 16'hFFFF);
    add_term(16'd1, 24'd500000, 16'd0);
    add_term(16'd1, 24'hFFFFFF, 16'd10);
    add_term(16'd0, 24'd10, 16'd50);
    wait_drained();
    write_reg(CfgSatK, 24'd0);
    write_reg(CfgLenNrmB, 24'd4096);
    // Zero term count with zero k gives a zero denominator.
    add_term(16'd0, 24'd5, 16'd50);
    add_term(16'd7, 24'd5, 16'd0);
    wait_drained();
    write_reg(CfgAvgLen, 24'd0);
    add_term(16'd5, 24'd5, 16'd5);
    add_term(16'd5, 24'hFFFFFF, 16'd5);
    wait_drained();

    for (int s = 0; s < 6; s++) begin
      write_reg(CfgAvgLen, settings[s].avg);
      write_reg(CfgCollSz, settings[s].n);
      write_reg(CfgSatK, 24'(settings[s].k));
      write_reg(CfgLenNrmB, 24'(settings[s].b));
      if (s == 1) begin
        // Results held back long enough that the unit fills and stalls input.
        stall_results = 1'b1;
        burst_mode = 1'b1;
        repeat (100) add_random_term();
        repeat (300) @(posedge clk_i);
        stall_results = 1'b0;
        wait_drained();
        burst_mode = 1'b0;
      end
      repeat (190) add_random_term();
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[bm25_term_weight_unit.f]
rtl/bm25tw_pkg.sv
rtl/bm25tw_fifo.sv
rtl/bm25tw_front.sv
rtl/bm25tw_back.sv
rtl/bm25_term_weight_unit.sv
tb/bm25_term_weight_unit_tb.sv
